>>> sv/generational_handle_table_defines.svh
// Assertion macros used by the handle table datapath.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define GHT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define GHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/ght_pkg.sv
package ght_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int HANDLE_IDX_W = 8;
   localparam int HANDLE_GEN_W = 16;
   localparam int IDENT_W = 32;
   localparam int STATUS_W = 2;
   localparam int LIVE_W = 9;

   // Request codes. Code three is treated as a lookup.
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [HANDLE_IDX_W-1:0] handle_index;
      logic [HANDLE_GEN_W-1:0] handle_generation;
      logic [IDENT_W-1:0] body_ident;
   } ght_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_IDX_W-1:0] out_index;
      logic [HANDLE_GEN_W-1:0] out_generation;
      logic [IDENT_W-1:0] stored_ident;
      logic [LIVE_W-1:0] live_count;
   } ght_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic look;
      logic commit;
   } ght_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic rsp_full;
   } ght_stat_type;

endpackage

>>> sv/ght_ram.sv
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ght_ctrl.sv
module ght_ctrl
   import ght_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   input  ght_stat_type stat,
   output ght_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       exec_done;

   // The update may retire only when the result register can take it.
   assign exec_done = !stat.rsp_full || rsp_ready;

   always_comb begin
      cmd.commit = (state_ff == ST_EXEC) && exec_done;
      cmd.look = (state_ff == ST_LOOK);
      req_ready = (state_ff == ST_IDLE) || cmd.commit;
      cmd.load_req = req_valid && req_ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_req) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = cmd.load_req ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/ght_dp.sv
`include "generational_handle_table_defines.svh"

module ght_dp
   import ght_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  ght_cmd_type  cmd,
   output ght_stat_type stat,
   input  ght_req_type  req_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output ght_rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W = GEN_BITS + 1;

   ght_req_type        req_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [IDX_W-1:0]   slot_in;
   logic               pop_ff;
   logic               fresh_ff;
   logic               in_range_ff;
   logic [CNT_W-1:0]   free_top_ff;
   logic [CNT_W-1:0]   free_top_in;
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   used_in;
   logic [CNT_W-1:0]   alive_ff;
   logic [CNT_W-1:0]   alive_in;
   logic               byp_valid_ff;
   logic [IDX_W-1:0]   byp_ff;
   logic               rsp_valid_ff;
   ght_rsp_type        rsp_ff;
   ght_rsp_type        rsp_in;

   logic [IDX_W-1:0]   stack_rd;
   logic [IDX_W-1:0]   stack_top;
   logic [IDX_W-1:0]   stack_rd_addr;
   logic [ENTRY_W-1:0] entry_rd;
   logic [ENTRY_W-1:0] entry_wr;
   logic [IDENT_W-1:0] ident_rd;

   logic               is_alloc;
   logic               is_free;
   logic               have_stack;
   logic               have_fresh;
   logic               in_range;
   logic               entry_alive;
   logic [GEN_BITS-1:0] entry_gen;
   logic [GEN_BITS-1:0] base_gen;
   logic [GEN_BITS-1:0] gen_inc;
   logic [GEN_BITS-1:0] new_gen;
   logic               alloc_have;
   logic               handle_ok;
   logic               do_alloc;
   logic               do_free;
   logic               push;

   // Lookup phase: pick the slot whose entry is read.
   always_comb begin
      is_alloc = (req_ff.req_type == REQ_ALLOC);
      is_free = (req_ff.req_type == REQ_FREE);
      have_stack = (free_top_ff != '0);
      have_fresh = (used_ff != CNT_W'(SLOT_COUNT));
      stack_top = byp_valid_ff ? byp_ff : stack_rd;
      in_range = 32'(req_ff.handle_index) < 32'(used_ff);
      if (is_alloc) begin
         slot_in = have_stack ? stack_top : IDX_W'(used_ff);
      end else begin
         slot_in = IDX_W'(req_ff.handle_index);
      end
   end

   // Execute phase: validate, update the slot and the counters, form the result.
   always_comb begin
      entry_alive = entry_rd[GEN_BITS];
      entry_gen = entry_rd[GEN_BITS-1:0];
      base_gen = fresh_ff ? '0 : entry_gen;
      gen_inc = base_gen + GEN_BITS'(1);
      new_gen = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
      alloc_have = pop_ff || fresh_ff;
      handle_ok = (req_ff.handle_generation != '0) && in_range_ff && entry_alive
                  && (32'(entry_gen) == 32'(req_ff.handle_generation));
      do_alloc = cmd.commit && is_alloc && alloc_have;
      do_free = cmd.commit && is_free && handle_ok;
      push = do_free && (free_top_ff < CNT_W'(SLOT_COUNT));
      entry_wr = do_alloc ? {1'b1, new_gen} : {1'b0, entry_gen};

      free_top_in = free_top_ff;
      if (do_alloc && pop_ff) begin
         free_top_in = free_top_ff - CNT_W'(1);
      end else if (push) begin
         free_top_in = free_top_ff + CNT_W'(1);
      end
      used_in = (do_alloc && fresh_ff) ? used_ff + CNT_W'(1) : used_ff;
      alive_in = alive_ff;
      if (do_alloc) begin
         alive_in = alive_ff + CNT_W'(1);
      end else if (do_free && (alive_ff != '0)) begin
         alive_in = alive_ff - CNT_W'(1);
      end
      stack_rd_addr = IDX_W'(free_top_in - CNT_W'(1));

      rsp_in.status = ST_OK;
      rsp_in.out_index = req_ff.handle_index;
      rsp_in.out_generation = req_ff.handle_generation;
      rsp_in.stored_ident = '0;
      rsp_in.live_count = LIVE_W'(alive_in);
      if (is_alloc) begin
         if (alloc_have) begin
            rsp_in.out_index = HANDLE_IDX_W'(slot_ff);
            rsp_in.out_generation = HANDLE_GEN_W'(new_gen);
         end else begin
            rsp_in.status = ST_FULL;
            rsp_in.out_index = '0;
            rsp_in.out_generation = '0;
         end
      end else if (!handle_ok) begin
         rsp_in.status = ST_STALE;
      end else if (!is_free) begin
         rsp_in.stored_ident = ident_rd;
      end
   end

   ght_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_entry_ram (
      .clock   (clock),
      .wr_en   (do_alloc || do_free),
      .wr_addr (slot_ff),
      .wr_data (entry_wr),
      .rd_addr (slot_in),
      .rd_data (entry_rd)
   );

   ght_ram #(.WIDTH(IDENT_W), .DEPTH(SLOT_COUNT)) u_ident_ram (
      .clock   (clock),
      .wr_en   (do_alloc),
      .wr_addr (slot_ff),
      .wr_data (req_ff.body_ident),
      .rd_addr (slot_in),
      .rd_data (ident_rd)
   );

   ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (IDX_W'(free_top_ff)),
      .wr_data (slot_ff),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.look) begin
         slot_ff <= slot_in;
         pop_ff <= is_alloc && have_stack;
         fresh_ff <= is_alloc && !have_stack && have_fresh;
         in_range_ff <= in_range;
      end
      if (cmd.commit) begin
         byp_ff <= slot_ff;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff <= '0;
         used_ff <= '0;
         alive_ff <= '0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_top_ff <= free_top_in;
         used_ff <= used_in;
         alive_ff <= alive_in;
         if (cmd.commit) begin
            byp_valid_ff <= push;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.rsp_full = rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Every used slot is either alive or parked on the free stack.
   `GHT_ASSERT_ALWAYS(a_slot_balance, clock, reset, (32'(alive_ff) + 32'(free_top_ff)) == 32'(used_ff), "alive plus free slots differ from used slots")
   `GHT_ASSERT_IMPLY(a_no_null_gen, clock, reset, do_alloc, new_gen != '0, "allocate produced the null generation")
   `GHT_ASSERT_IMPLY(a_stack_room, clock, reset, do_free, free_top_ff < CNT_W'(SLOT_COUNT), "free with a full free stack")

endmodule

>>> sv/generational_handle_table.sv
// Generational handle table. Allocate (req_type 0) stores body_ident in a slot taken
// from the top of a LIFO free stack, or else in the next never-used slot, bumps that
// slot's generation (skipping 0, the null generation) and returns the new handle; when
// no slot is left it reports table full. Free (1) and lookup (2, and also 3) check the
// handle for a non-null generation, an index below the number of slots ever used, an
// alive slot and a matching generation; free then retires the slot onto the free stack,
// lookup returns the stored identifier, and a bad handle reports status 2 with nothing
// changed. Every result beat carries the live slot count after the request. A request
// beat first reads the free stack top and picks the slot, then reads that slot's entry
// and writes it back, so a new request is taken only as the previous one retires,
// held back by that read-modify-write of the slot RAMs; the result is registered as
// the update retires. A new request beat is taken in the same cycle a result is
// written to the output register, so a result waiting on rsp_ready does not hold
// off the next request until that request itself must retire. Slot entries are
// only trusted below the used-slot count, so no clearing pass runs after reset and
// the table accepts requests from the first cycle.
module generational_handle_table
   import ght_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ght_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ght_rsp_type rsp_data
);

   // Command and status between the sequencer and the datapath.
   ght_cmd_type  cmd;
   ght_stat_type stat;

   // The sequencer walks each request through its slot pick and its update.
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the slot RAMs, the free stack and the counters.
   ght_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .GEN_BITS   (GEN_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/ght_tb_pkg.sv
package ght_tb_pkg;
   import ght_pkg::*;

   localparam int TABLE_SLOTS = 256;
   localparam int REPORT_LIMIT = 10;

   // The hardware decodes the unused request code as a lookup.
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP_ALIAS = 2'd3;

   class handle_table_scoreboard_type;
      // Mirror of the slot table, updated in the order request beats are accepted.
      bit [IDENT_W-1:0] body_of_slot [TABLE_SLOTS];
      bit [HANDLE_GEN_W-1:0] gen_of_slot [TABLE_SLOTS];
      bit slot_is_alive [TABLE_SLOTS];
      bit [HANDLE_IDX_W-1:0] free_slots [TABLE_SLOTS];
      int unsigned stack_depth;
      int unsigned used_slots;
      int unsigned live_slots;

      // Most recent handles handed out and retired, for building follow-up beats.
      bit [HANDLE_IDX_W-1:0] last_index;
      bit [HANDLE_GEN_W-1:0] last_gen;
      bit [HANDLE_IDX_W-1:0] last_freed_index;
      bit [HANDLE_GEN_W-1:0] last_freed_gen;

      ght_rsp_type predicted_q[$];
      int unsigned mismatch_count;

      function bit handle_live(bit [HANDLE_IDX_W-1:0] idx, bit [HANDLE_GEN_W-1:0] g);
         return g != '0 && idx < used_slots && slot_is_alive[idx] && gen_of_slot[idx] == g;
      endfunction

      // Picks a random alive slot and returns its current handle.
      function bit pick_live(output bit [HANDLE_IDX_W-1:0] idx,
                             output bit [HANDLE_GEN_W-1:0] g);
         int start;
         start = $urandom_range(0, TABLE_SLOTS - 1);
         idx = '0;
         g = '0;
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            int s;
            s = (start + k) % TABLE_SLOTS;
            if (slot_is_alive[s]) begin
               idx = HANDLE_IDX_W'(s);
               g = gen_of_slot[s];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(ght_req_type r);
         ght_rsp_type e;
         int slot;
         bit [HANDLE_GEN_W-1:0] g;
         e = '0;
         e.status = ST_OK;
         e.out_index = r.handle_index;
         e.out_generation = r.handle_generation;
         if (r.req_type == REQ_ALLOC) begin
            slot = -1;
            if (stack_depth > 0) begin
               stack_depth--;
               slot = int'(free_slots[stack_depth]);
            end else if (used_slots < TABLE_SLOTS) begin
               slot = int'(used_slots);
               used_slots++;
            end
            if (slot >= 0) begin
               g = gen_of_slot[slot] + HANDLE_GEN_W'(1);
               if (g == '0) g = HANDLE_GEN_W'(1);
               gen_of_slot[slot] = g;
               body_of_slot[slot] = r.body_ident;
               slot_is_alive[slot] = 1'b1;
               live_slots++;
               last_index = HANDLE_IDX_W'(slot);
               last_gen = g;
               e.out_index = HANDLE_IDX_W'(slot);
               e.out_generation = g;
            end else begin
               e.status = ST_FULL;
               e.out_index = '0;
               e.out_generation = '0;
            end
         end else if (r.req_type == REQ_FREE) begin
            if (handle_live(r.handle_index, r.handle_generation)) begin
               slot_is_alive[r.handle_index] = 1'b0;
               free_slots[stack_depth] = r.handle_index;
               stack_depth++;
               live_slots--;
               last_freed_index = r.handle_index;
               last_freed_gen = r.handle_generation;
            end else begin
               e.status = ST_STALE;
            end
         end else begin
            if (handle_live(r.handle_index, r.handle_generation))
               e.stored_ident = body_of_slot[r.handle_index];
            else
               e.status = ST_STALE;
         end
         e.live_count = LIVE_W'(live_slots);
         predicted_q.insert(predicted_q.size(), e);
      endfunction

      function string show(ght_rsp_type p);
         return $sformatf("status=%0d index=%0d gen=%0d ident=%h live=%0d", p.status,
                          p.out_index, p.out_generation, p.stored_ident, p.live_count);
      endfunction

      function void check_result(ght_rsp_type got);
         ght_rsp_type e;
         if (predicted_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: result beat with nothing outstanding: %s", show(got));
            return;
         end
         e = predicted_q.pop_front();
         if (got.status !== e.status || got.out_index !== e.out_index ||
             got.out_generation !== e.out_generation ||
             got.stored_ident !== e.stored_ident || got.live_count !== e.live_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("ERROR: result beat differs");
               $display("   expected %s", show(e));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

endpackage

>>> bench/generational_handle_table_tb.sv
module generational_handle_table_tb;
   import ght_pkg::*;
   import ght_tb_pkg::*;

   // Worst correct run: about 1.7k request beats, each with a random idle gap from
   // draw_gap on each side plus the slot pick and update. The limit leaves a wide
   // margin.
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int DRAIN_CYCLES = 32;
   localparam int SEGMENT_ITEMS = 150;
   localparam int RANDOM_SEGMENTS = 11;
   // Allocate/free rounds on one slot at the end of the run.
   localparam int REUSE_ROUNDS = 20;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ght_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ght_rsp_type rsp_data;

   int unsigned cycle_count = 0;

   // When set, neither side inserts idle cycles, so beats go back to back.
   bit calm = 1'b0;

   handle_table_scoreboard_type sb = new();

   generational_handle_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   // Presents one request beat and returns at the edge where it is accepted. Valid is
   // left high on return, so a beat that follows with no gap keeps it high without a
   // second assignment in the same time step.
   task automatic send_beat(input ght_req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   function automatic ght_req_type make_req(logic [REQ_TYPE_W-1:0] kind,
                                            int idx, int g, logic [IDENT_W-1:0] ident);
      ght_req_type r;
      r.req_type = kind;
      r.handle_index = HANDLE_IDX_W'(idx);
      r.handle_generation = HANDLE_GEN_W'(g);
      r.body_ident = ident;
      return r;
   endfunction

   // Builds a random request. Most beats are well formed: allocations and frees or
   // lookups of handles that are alive right now. The rest are bad handles of every
   // flavor: random, one generation bit off, null, beyond the used range, and the
   // handle most recently freed (dead, or stale once its slot was reused).
   function automatic ght_req_type random_request(traffic_mix_type mix);
      ght_req_type r;
      int roll;
      int alloc_cut;
      int free_cut;
      int look_cut;
      bit found;
      bit [HANDLE_IDX_W-1:0] idx;
      bit [HANDLE_GEN_W-1:0] g;
      r.req_type = REQ_ALLOC;
      r.handle_index = HANDLE_IDX_W'($urandom);
      r.handle_generation = HANDLE_GEN_W'($urandom);
      r.body_ident = $urandom;
      case (mix)
         MIX_FILL: begin
            alloc_cut = 80; free_cut = 85; look_cut = 95;
         end
         MIX_DRAIN: begin
            alloc_cut = 15; free_cut = 65; look_cut = 85;
         end
         default: begin
            alloc_cut = 35; free_cut = 65; look_cut = 85;
         end
      endcase
      roll = $urandom_range(0, 99);
      found = sb.pick_live(idx, g);
      if (roll < alloc_cut) begin
         r.req_type = REQ_ALLOC;
      end else if (roll < look_cut && found) begin
         if (roll < free_cut)
            r.req_type = REQ_FREE;
         else
            r.req_type = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_LOOKUP_ALIAS;
         r.handle_index = idx;
         r.handle_generation = g;
      end else begin
         case ($urandom_range(0, 2))
            0: r.req_type = REQ_FREE;
            1: r.req_type = REQ_LOOKUP;
            default: r.req_type = REQ_LOOKUP_ALIAS;
         endcase
         case ($urandom_range(0, 4))
            0: ;
            1: if (found) begin
               r.handle_index = idx;
               r.handle_generation = g ^ (HANDLE_GEN_W'(1) << $urandom_range(0, 15));
            end
            2: begin
               if (found) r.handle_index = idx;
               r.handle_generation = '0;
            end
            3: if (sb.used_slots < TABLE_SLOTS) begin
               r.handle_index = HANDLE_IDX_W'($urandom_range(sb.used_slots, TABLE_SLOTS - 1));
               r.handle_generation = HANDLE_GEN_W'($urandom_range(1, 65535));
            end
            default: begin
               r.handle_index = sb.last_freed_index;
               r.handle_generation = sb.last_freed_gen;
            end
         endcase
      end
      return r;
   endfunction

   // Result side: before every beat, rsp_ready is held low for a random number of
   // cycles, then raised until a result beat is taken. Each accepted beat is checked
   // against the oldest predicted result.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   initial begin
      traffic_mix_type mix;
      bit [HANDLE_IDX_W-1:0] idx;
      bit [HANDLE_GEN_W-1:0] g;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats on a fresh table. Null and out-of-range handles first, then
      // identifiers at both extremes, lookups through both lookup codes, stale and
      // dead handles, a double free, and LIFO reuse of freed slots with bumped
      // generations.
      send_beat(make_req(REQ_LOOKUP, 0, 0, 32'h0));
      send_beat(make_req(REQ_FREE, 255, 16'hFFFF, 32'hFFFF_FFFF));
      send_beat(make_req(REQ_ALLOC, 255, 16'hFFFF, 32'h0000_0000));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'hFFFF_FFFF));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'hA5A5_5A5A));
      send_beat(make_req(REQ_LOOKUP, 0, 1, 32'hFFFF_FFFF));
      send_beat(make_req(REQ_LOOKUP_ALIAS, 1, 1, 32'h0));
      send_beat(make_req(REQ_LOOKUP, 1, 2, 32'h0));
      send_beat(make_req(REQ_LOOKUP, 2, 0, 32'h0));
      send_beat(make_req(REQ_LOOKUP, 3, 1, 32'h0));
      send_beat(make_req(REQ_FREE, 1, 1, 32'h0));
      send_beat(make_req(REQ_FREE, 1, 1, 32'h0));
      send_beat(make_req(REQ_LOOKUP, 1, 1, 32'h0));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'h1234_5678));
      send_beat(make_req(REQ_LOOKUP, 1, 2, 32'h0));
      send_beat(make_req(REQ_LOOKUP, 1, 1, 32'h0));
      send_beat(make_req(REQ_FREE, 0, 1, 32'h0));
      send_beat(make_req(REQ_FREE, 2, 1, 32'h0));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'h8000_0001));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'h7FFF_FFFE));
      send_beat(make_req(REQ_ALLOC, 0, 0, 32'hDEAD_0003));
      send_beat(make_req(REQ_LOOKUP_ALIAS, 255, 16'hFFFF, 32'h0));

      // Random traffic in segments. The opening segments lean on allocation so the
      // table fills and allocations report it full; later segments mix at random
      // between filling, draining and a balanced load, some with no idle cycles.
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         mix = (seg < 3) ? MIX_FILL : traffic_mix_type'($urandom_range(0, 2));
         calm = (seg >= 3) && ($urandom_range(0, 3) == 0);
         repeat (SEGMENT_ITEMS) send_beat(random_request(mix));
      end

      // Slot reuse: with a free slot on top of the stack, allocating and freeing it
      // over and over reuses the same slot, so its generation climbs every round.
      calm = 1'b1;
      if (sb.live_slots == TABLE_SLOTS) begin
         void'(sb.pick_live(idx, g));
         send_beat(make_req(REQ_FREE, idx, g, $urandom));
      end
      repeat (REUSE_ROUNDS) begin
         send_beat(make_req(REQ_ALLOC, $urandom, $urandom, $urandom));
         send_beat(make_req(REQ_FREE, sb.last_index, sb.last_gen, $urandom));
      end
      send_beat(make_req(REQ_LOOKUP, sb.last_freed_index, sb.last_freed_gen, $urandom));
      req_valid <= 1'b0;

      // Let every outstanding result come back, then give stray beats a chance to
      // show up before the verdict.
      while (sb.predicted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.predicted_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> generational_handle_table.f
+incdir+sv
sv/ght_pkg.sv
sv/ght_ram.sv
sv/ght_ctrl.sv
sv/ght_dp.sv
sv/generational_handle_table.sv
bench/ght_tb_pkg.sv
bench/generational_handle_table_tb.sv
